/* rtl/gfba_pkg.sv */
// Shared constants, codes and control types for the grouped free-block allocator.
package gfba_pkg;

    localparam int BLK_W     = 10;
    localparam int FT_W      = 11;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = STAT_W;

    localparam int DEF_GROUP_SIZE = 8;
    localparam int DEF_NUM_BLOCKS = 1024;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STAT_W-1:0] ST_REFUSED = 2'd2;

    typedef struct packed {
        logic              capture;
        logic              set_code;
        logic [STAT_W-1:0] code;
        logic              rd_top;
        logic              push;
        logic              spill_start;
        logic              take_top;
        logic              pop;
        logic              rd_cnt;
        logic              reload_start;
        logic              loop_step;
        logic              loop_end;
        logic              emit;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic no_free;
        logic refused;
        logic top_zero;
        logic top_last;
        logic loop_done;
        logic out_free;
    } sts_t;

endpackage

/* rtl/gfba_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module gfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/gfba_ctrl.sv */
// Request sequencer: decodes each transaction into datapath commands.
module gfba_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  gfba_pkg::sts_t sts,
    output gfba_pkg::cmd_t cmd
);
    import gfba_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_TOPW = 3'd2;
    localparam logic [2:0] S_CNTW = 3'd3;
    localparam logic [2:0] S_LOOP = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_DONE;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.set_code = 1'b1;
                if (!sts.is_free) begin
                    if (sts.no_free) begin
                        cmd.code   = ST_NO_FREE;
                        state_next = S_EMIT;
                    end else begin
                        cmd.rd_top = 1'b1;
                        state_next = S_TOPW;
                    end
                end else if (sts.refused) begin
                    cmd.code   = ST_REFUSED;
                    state_next = S_EMIT;
                end else if (sts.top_zero) begin
                    cmd.spill_start = 1'b1;
                    state_next      = S_LOOP;
                end else begin
                    cmd.push   = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_TOPW: begin
                cmd.take_top = 1'b1;
                if (sts.top_last) begin
                    cmd.rd_cnt = 1'b1;
                    state_next = S_CNTW;
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_CNTW: begin
                cmd.reload_start = 1'b1;
                state_next       = S_LOOP;
            end
            S_LOOP: begin
                if (sts.loop_done) begin
                    cmd.loop_end = 1'b1;
                    state_next   = S_EMIT;
                end else begin
                    cmd.loop_step = 1'b1;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/gfba_dpath.sv */
// Datapath: group stack, chain store, counters and the result register.
module gfba_dpath #(
    parameter int GROUP_SIZE = gfba_pkg::DEF_GROUP_SIZE,
    parameter int NUM_BLOCKS = gfba_pkg::DEF_NUM_BLOCKS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  gfba_pkg::cmd_t                 cmd,
    output gfba_pkg::sts_t                 sts,
    input  logic [gfba_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [gfba_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gfba_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [gfba_pkg::M_TUSER_W-1:0] m_tuser
);
    import gfba_pkg::*;

    localparam int SA_W  = $clog2(GROUP_SIZE);
    localparam int TOP_W = $clog2(GROUP_SIZE + 1);
    localparam int BA_W  = $clog2(NUM_BLOCKS);
    localparam int CH_AW = $clog2(NUM_BLOCKS * GROUP_SIZE);
    localparam int FC_W  = $clog2(NUM_BLOCKS + 1);

    logic              req_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [CH_AW-1:0]  base_reg;
    logic [TOP_W-1:0]  top_reg;
    logic [TOP_W-1:0]  top_next;
    logic [FC_W-1:0]   fc_reg;
    logic [FC_W-1:0]   fc_next;
    logic [TOP_W-1:0]  rd_idx_reg;
    logic [TOP_W-1:0]  wr_idx_reg;
    logic [TOP_W-1:0]  lim_reg;
    logic              pend_reg;
    logic [STAT_W-1:0] code_reg;
    logic [BLK_W-1:0]  granted_reg;
    logic              m_tvalid_reg;
    logic [BLK_W-1:0]  m_granted_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [FT_W-1:0]   m_total_reg;

    logic [BLK_W-1:0]  st_wdata, st_rdata, ch_rdata;
    logic [SA_W-1:0]   st_waddr, st_raddr, rd_ofs, wr_ofs;
    logic              st_we, st_re, ch_we, ch_re, cnt_we, cnt_re;
    logic [CH_AW-1:0]  ch_waddr, ch_raddr;
    logic [BA_W-1:0]   blk_addr, top_addr;
    logic [TOP_W-1:0]  cnt_wdata, cnt_rdata, cnt_clamp, top_dec;
    logic [BA_W+BLK_W-1:0] blk_wide, top_wide;
    logic [FC_W+FT_W-1:0]  fc_wide;
    logic [BLK_W-1:0]  in_blk;
    logic              loop_rd, loop_wr;

    assign in_blk   = s_tdata[BLK_W-1:0];
    assign blk_wide = {{BA_W{1'b0}}, blk_reg};
    assign blk_addr = blk_wide[BA_W-1:0];
    assign top_wide = {{BA_W{1'b0}}, st_rdata};
    assign top_addr = top_wide[BA_W-1:0];
    assign fc_wide  = {{FT_W{1'b0}}, fc_reg};
    assign top_dec  = top_reg - TOP_W'(1);

    assign loop_rd = cmd.loop_step && (rd_idx_reg < lim_reg);
    assign loop_wr = cmd.loop_step && pend_reg;
    assign rd_ofs  = SA_W'(GROUP_SIZE - 1) - rd_idx_reg[SA_W-1:0];
    assign wr_ofs  = SA_W'(GROUP_SIZE - 1) - wr_idx_reg[SA_W-1:0];

    assign cnt_clamp = (cnt_rdata > TOP_W'(GROUP_SIZE)) ? TOP_W'(GROUP_SIZE) : cnt_rdata;

    // group stack port selection
    assign st_we    = cmd.push || (loop_wr && !req_reg) || (cmd.loop_end && req_reg);
    assign st_waddr = cmd.push ? top_dec[SA_W-1:0] :
                      (loop_wr ? wr_ofs : SA_W'(GROUP_SIZE - 1));
    assign st_wdata = (loop_wr && !req_reg) ? ch_rdata : blk_reg;
    assign st_re    = cmd.rd_top || (loop_rd && req_reg);
    assign st_raddr = cmd.rd_top ? top_reg[SA_W-1:0] : rd_ofs;

    // chain store port selection
    assign ch_we    = loop_wr && req_reg;
    assign ch_waddr = base_reg + CH_AW'(wr_idx_reg);
    assign ch_re    = loop_rd && !req_reg;
    assign ch_raddr = base_reg + CH_AW'(rd_idx_reg);

    assign cnt_we    = cmd.push || (cmd.loop_end && req_reg);
    assign cnt_wdata = cmd.push ? '0 : TOP_W'(GROUP_SIZE);
    assign cnt_re    = cmd.rd_cnt;

    gfba_ram #(.WIDTH(BLK_W), .DEPTH(GROUP_SIZE)) u_stack_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    gfba_ram #(.WIDTH(BLK_W), .DEPTH(NUM_BLOCKS * GROUP_SIZE)) u_chain_ram (
        .aclk  (aclk),
        .we    (ch_we),
        .waddr (ch_waddr),
        .wdata (st_rdata),
        .re    (ch_re),
        .raddr (ch_raddr),
        .rdata (ch_rdata)
    );

    gfba_ram #(.WIDTH(TOP_W), .DEPTH(NUM_BLOCKS)) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (blk_addr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (top_addr),
        .rdata (cnt_rdata)
    );

    always_comb begin
        top_next = top_reg;
        fc_next  = fc_reg;
        if (cmd.push) begin
            top_next = top_dec;
            fc_next  = fc_reg + FC_W'(1);
        end
        if (cmd.pop) begin
            top_next = top_reg + TOP_W'(1);
            fc_next  = fc_reg - FC_W'(1);
        end
        if (cmd.loop_end) begin
            if (req_reg) begin
                top_next = TOP_W'(GROUP_SIZE - 1);
                fc_next  = fc_reg + FC_W'(1);
            end else begin
                top_next = TOP_W'(GROUP_SIZE) - lim_reg;
                fc_next  = fc_reg - FC_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg      <= TOP_W'(GROUP_SIZE);
            fc_reg       <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            top_reg <= top_next;
            fc_reg  <= fc_next;
            if (cmd.spill_start || cmd.reload_start) begin
                pend_reg <= 1'b0;
            end else if (cmd.loop_step) begin
                pend_reg <= loop_rd;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg  <= s_tuser[0];
            blk_reg  <= in_blk;
            base_reg <= CH_AW'(in_blk) * CH_AW'(GROUP_SIZE);
        end
        if (cmd.set_code) begin
            code_reg    <= cmd.code;
            granted_reg <= '0;
        end
        if (cmd.take_top) begin
            granted_reg <= st_rdata;
            base_reg    <= CH_AW'(st_rdata) * CH_AW'(GROUP_SIZE);
        end
        if (cmd.spill_start) begin
            lim_reg    <= TOP_W'(GROUP_SIZE);
            rd_idx_reg <= '0;
        end
        if (cmd.reload_start) begin
            lim_reg    <= cnt_clamp;
            rd_idx_reg <= '0;
        end
        if (loop_rd) begin
            rd_idx_reg <= rd_idx_reg + TOP_W'(1);
            wr_idx_reg <= rd_idx_reg;
        end
        if (cmd.emit) begin
            m_granted_reg <= granted_reg;
            m_status_reg  <= code_reg;
            m_total_reg   <= fc_wide[FT_W-1:0];
        end
    end

    assign sts.is_free   = (req_reg == REQ_FREE);
    assign sts.no_free   = (fc_reg == '0) || (top_reg >= TOP_W'(GROUP_SIZE));
    assign sts.refused   = (32'(blk_reg) >= 32'(NUM_BLOCKS)) || (32'(fc_reg) >= 32'(NUM_BLOCKS));
    assign sts.top_zero  = (top_reg == '0);
    assign sts.top_last  = (top_reg == TOP_W'(GROUP_SIZE - 1));
    assign sts.loop_done = (rd_idx_reg == lim_reg) && !pend_reg;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - BLK_W - FT_W){1'b0}}, m_total_reg, m_granted_reg};
    assign m_tuser  = m_status_reg;

endmodule

/* rtl/grouped_free_block_allocator.sv */
// Top level of the grouped free-block allocator: sequencer plus datapath.
//
//  channel | direction | tdata (low bit up)                    | tuser
//  s_      | in        | block_id[9:0], zero pad to 16          | req_type
//  m_      | out       | granted_block[9:0], free_total[20:10]  | status[1:0]
//
//  One transaction at a time; s_tready is high only in the idle state.
//  Push or rejected request: EVAL, then EMIT after acceptance; pop passes TOPW between them.
//  Spill and reload run a one-entry-per-cycle copy between the group stack RAM and
//  the chain RAM: all GROUP_SIZE entries on a spill, the record count, at most
//  GROUP_SIZE, on a reload, which first passes TOPW and CNTW.
//  A result waiting on m_tready does not block acceptance of the next request;
//  the following result holds in the sequencer until the output register frees.
//  Reset is synchronous; the chain and stack RAMs need no clearing pass.
module grouped_free_block_allocator #(
    parameter int GROUP_SIZE = gfba_pkg::DEF_GROUP_SIZE,
    parameter int NUM_BLOCKS = gfba_pkg::DEF_NUM_BLOCKS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gfba_pkg::S_TDATA_W-1:0] s_tdata,  // block_id
    input  logic [gfba_pkg::S_TUSER_W-1:0] s_tuser,  // req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gfba_pkg::M_TDATA_W-1:0] m_tdata,  // granted_block, free_total
    output logic [gfba_pkg::M_TUSER_W-1:0] m_tuser   // status
);
    import gfba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    gfba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gfba_dpath #(
        .GROUP_SIZE (GROUP_SIZE),
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/gfba_checker.sv */
// Port-level checks for the grouped free-block allocator, bound to the top level.
module gfba_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [gfba_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [gfba_pkg::M_TUSER_W-1:0] m_tuser
);
    import gfba_pkg::*;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request accepted while one is in work");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == ST_DONE || m_tuser == ST_NO_FREE || m_tuser == ST_REFUSED)
        else $error("unknown status code");

    a_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_DONE |-> m_tdata[BLK_W-1:0] == '0)
        else $error("nonzero block on failed request");

endmodule

bind grouped_free_block_allocator gfba_checker u_gfba_checker (.*);

/* test/tb_top.sv */
// Self-checking testbench for the grouped free-block allocator: stream driver, result monitor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gfba_pkg::*;

    localparam int GS = DEF_GROUP_SIZE;
    localparam int NB = DEF_NUM_BLOCKS;

    typedef struct packed {
        logic             req;
        logic [BLK_W-1:0] blk;
    } alloc_req_t;

    typedef struct packed {
        logic [BLK_W-1:0]  granted;
        logic [STAT_W-1:0] status;
        logic [FT_W-1:0]   total;
    } grant_rec_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    grouped_free_block_allocator DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // allocator shadow state
    logic [BLK_W-1:0] stk [GS];
    int unsigned      stk_top = GS;
    int unsigned      nfree = 0;
    logic [BLK_W-1:0] rec_ent [NB][GS];
    logic [3:0]       rec_cnt [NB];
    bit               believed_free [NB];

    alloc_req_t  pending[$];
    grant_rec_t  grants_due[$];
    alloc_req_t  cur_req;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned idle_pct = 0;
    int unsigned n_errors = 0;
    int unsigned n_accepted = 0;
    int unsigned n_grants = 0;
    int unsigned n_empty = 0;
    int unsigned n_refused = 0;
    int unsigned n_reloads = 0;
    int unsigned n_spills = 0;
    int unsigned peak_free = 0;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        n_errors++;
    endtask

    function automatic void apply_request(input alloc_req_t r, output grant_rec_t g);
        int unsigned b;
        int unsigned n;
        g.granted = '0;
        g.status  = ST_DONE;
        if (r.req == REQ_ALLOC) begin
            if (nfree == 0 || stk_top >= GS) begin
                g.status = ST_NO_FREE;
                n_empty++;
            end else begin
                b = stk[stk_top];
                if (stk_top == GS - 1) begin
                    n = rec_cnt[b];
                    if (n > GS) n = GS;
                    for (int i = 0; i < n; i++) stk[GS-1-i] = rec_ent[b][i];
                    stk_top = GS - n;
                    n_reloads++;
                end else begin
                    stk_top++;
                end
                nfree--;
                g.granted = b[BLK_W-1:0];
                believed_free[b] = 1'b0;
                n_grants++;
            end
        end else begin
            b = r.blk;
            if (nfree >= NB) begin
                g.status = ST_REFUSED;
                n_refused++;
            end else begin
                if (stk_top == 0) begin
                    for (int i = 0; i < GS; i++) rec_ent[b][i] = stk[GS-1-i];
                    rec_cnt[b] = 4'(GS);
                    stk_top = GS - 1;
                    n_spills++;
                end else begin
                    for (int i = 0; i < GS; i++) rec_ent[b][i] = '0;
                    rec_cnt[b] = '0;
                    stk_top--;
                end
                stk[stk_top] = r.blk;
                nfree++;
                if (nfree > peak_free) peak_free = nfree;
            end
        end
        g.total = nfree[FT_W-1:0];
    endfunction

    // driver: hold until accepted, advance from the pending queue
    always @(posedge aclk) begin
        grant_rec_t g;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_request(cur_req, g);
                grants_due.push_back(g);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending.size() > 0 && $urandom_range(99) < idle_pct) begin
                    gap_left = $urandom_range(6);
                    s_tvalid <= 1'b0;
                end else if (pending.size() > 0) begin
                    cur_req = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W-BLK_W){1'b0}}, cur_req.blk};
                    s_tuser  <= cur_req.req;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        grant_rec_t exp_g;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (grants_due.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    exp_g = grants_due.pop_front();
                    if (m_tdata[BLK_W-1:0] !== exp_g.granted)
                        report_mismatch($sformatf("granted_block %0d, expected %0d",
                                                  m_tdata[BLK_W-1:0], exp_g.granted));
                    if (m_tuser !== exp_g.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_tuser, exp_g.status));
                    if (m_tdata[BLK_W+FT_W-1:BLK_W] !== exp_g.total)
                        report_mismatch($sformatf("free_total %0d, expected %0d",
                                                  m_tdata[BLK_W+FT_W-1:BLK_W], exp_g.total));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if ($urandom_range(99) < idle_pct) begin
                stall_left = $urandom_range(6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [BLK_W-1:0] pick_block(input bit fresh);
        int unsigned start;
        int unsigned k;
        start = $urandom_range(NB - 1);
        if (fresh)
            for (k = 0; k < NB; k++)
                if (!believed_free[(start + k) % NB]) return BLK_W'((start + k) % NB);
        return BLK_W'(start);
    endfunction

    task automatic queue_req(input logic req, input logic [BLK_W-1:0] blk);
        alloc_req_t r;
        do @(negedge aclk); while (pending.size() != 0);
        r.req = req;
        r.blk = blk;
        pending.push_back(r);
        if (req == REQ_FREE) believed_free[blk] = 1'b1;
    endtask

    // runs of same-kind requests walk the stack across group boundaries
    task automatic run_phase(input int unsigned count, input int unsigned alloc_pct,
                             input bit with_idle, input bit until_full);
        int unsigned issued;
        int unsigned run_len;
        logic        kind;
        issued = 0;
        while (issued < count && !(until_full && nfree >= NB)) begin
            kind = ($urandom_range(99) < alloc_pct) ? REQ_ALLOC : REQ_FREE;
            run_len = $urandom_range(1, 16);
            if (with_idle) begin
                case ($urandom_range(2))
                    0: idle_pct = 0;
                    1: idle_pct = 20;
                    default: idle_pct = 40;
                endcase
            end else begin
                idle_pct = 0;
            end
            for (int j = 0; j < run_len && issued < count; j++) begin
                if (kind == REQ_ALLOC)
                    queue_req(REQ_ALLOC, BLK_W'($urandom));
                else
                    queue_req(REQ_FREE, pick_block($urandom_range(99) >= 10));
                issued++;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        int unsigned k;
        wait (aresetn);
        idle_pct = 30;
        // allocate from an empty pool
        queue_req(REQ_ALLOC, 10'h3FF);
        // fill one group with edge block numbers
        queue_req(REQ_FREE, 10'd0);
        queue_req(REQ_FREE, 10'd1023);
        queue_req(REQ_FREE, 10'h155);
        queue_req(REQ_FREE, 10'h2AA);
        for (k = 1; k <= 4; k++) queue_req(REQ_FREE, BLK_W'(k));
        // free onto a full stack spills the group, then allocate the link to reload it
        queue_req(REQ_FREE, 10'd5);
        queue_req(REQ_ALLOC, 10'h2AA);
        // spill again, free the new link twice, then drain through its empty record
        queue_req(REQ_FREE, 10'd6);
        queue_req(REQ_FREE, 10'd6);
        queue_req(REQ_ALLOC, 10'h155);
        queue_req(REQ_ALLOC, 10'd0);
        // empty stack with a nonzero count
        queue_req(REQ_ALLOC, 10'd1023);
        queue_req(REQ_FREE, 10'd7);
        queue_req(REQ_ALLOC, 10'd0);
        queue_req(REQ_ALLOC, 10'd0);

        run_phase(160, 50, 1'b1, 1'b0);
        run_phase(1500, 4, 1'b1, 1'b1);
        // refused frees at capacity, then a little churn right at the limit
        idle_pct = 20;
        for (k = 0; k < 6; k++) queue_req(REQ_FREE, pick_block(1'b0));
        for (k = 0; k < 3; k++) queue_req(REQ_ALLOC, BLK_W'($urandom));
        for (k = 0; k < 5; k++) queue_req(REQ_FREE, pick_block(1'b1));
        run_phase(120, 75, 1'b0, 1'b0);
        idle_pct = 0;

        do @(negedge aclk);
        while (pending.size() != 0 || s_tvalid || grants_due.size() != 0);
        repeat (30) @(posedge aclk);
        if (grants_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", grants_due.size()));

        $display("%0d requests: %0d grants, %0d empty-pool replies, %0d refused frees",
                 n_accepted, n_grants, n_empty, n_refused);
        $display("%0d group reloads, %0d group spills, free count peaked at %0d",
                 n_reloads, n_spills, peak_free);
        if (n_errors == 0) begin
            $display("PASS grouped_free_block_allocator");
        end else begin
            $display("FAIL grouped_free_block_allocator");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout after %0d accepted requests", n_accepted);
        $display("FAIL grouped_free_block_allocator");
        $finish;
    end

endmodule

/* filelist.f */
rtl/gfba_pkg.sv
rtl/gfba_ram.sv
rtl/gfba_ctrl.sv
rtl/gfba_dpath.sv
rtl/grouped_free_block_allocator.sv
rtl/gfba_checker.sv
test/tb_top.sv
